@@ design/mfs_pkg.sv @@
// Shared constants, types and state codes for the multiplicative function sieve.
package mfs_pkg;

    localparam int MAX_N      = 4096;
    localparam int MAX_PRIMES = 564;

    localparam int N_W   = 13;   // numbers 0..MAX_N
    localparam int LPF_W = 12;   // stored least prime factor / quotient
    localparam int PL_AW = 10;   // prime list index and count
    localparam int MUL_W = 16;   // shared multiplier operand width

    localparam logic [N_W-1:0] TOP_MAX = N_W'(MAX_N);

    localparam logic [12:0] TOT_SAT = 13'h1FFF;
    localparam logic [6:0]  CNT_SAT = 7'h7F;
    localparam logic [15:0] SUM_SAT = 16'hFFFF;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

    localparam logic signed [1:0] MOB_ONE  = 2'sb01;
    localparam logic signed [1:0] MOB_NEG  = 2'sb11;
    localparam logic signed [1:0] MOB_ZERO = 2'sb00;

    typedef struct packed {
        logic signed [1:0] mob;
        logic [12:0]       tot;
        logic [6:0]        cnt;
        logic [15:0]       sum;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_INIT,
        ST_SRD,
        ST_SLPF,
        ST_SPRD,
        ST_SMUL,
        ST_SCHK,
        ST_FRD,
        ST_FP,
        ST_FDRD,
        ST_FDIV,
        ST_FACC,
        ST_PPW,
        ST_TRD1,
        ST_TRD2,
        ST_TM1,
        ST_TM2,
        ST_TM3,
        ST_TM4,
        ST_QRD,
        ST_QSET,
        ST_OUT
    } state_t;

endpackage

@@ design/mfs_mul.sv @@
// Shared registered multiplier used by sieve, prime power and combine steps.
module mfs_mul
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [mfs_pkg::MUL_W-1:0]     a,
    input  logic [mfs_pkg::MUL_W-1:0]     b,
    output logic [2*mfs_pkg::MUL_W-1:0]   prod
);

    logic [2*mfs_pkg::MUL_W-1:0] prod_reg;

    // product held until the next enabled operation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

@@ design/multiplicative_function_sieve_unit.sv @@
// Top level: table builder and lookup for Mobius, totient, divisor count and divisor sum.
//
// A transfer with func = build clears the smallest-prime-factor table, runs
// a linear sieve up to the saturated limit and then fills the function table
// (Mobius, totient, divisor count and divisor sum per entry): for each number
// it divides out the powers of its smallest prime, then writes a prime power
// directly or combines two table entries, all through one shared registered
// multiplier and single-port tables. A build answers one result with status
// 0 and zero values. A query result passes through a table read, a staging
// step and the output register. While an earlier result waits for out_ready,
// the next result holds the block in its output step. The block takes one
// item at a time; in_ready is high only while it is idle. The limit register
// is written through cfg_we / cfg_wdata; the user must write it only while
// idle, and the block itself does not enforce this. Queries keep the limit
// of the last build.
module multiplicative_function_sieve_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [12:0] index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic signed [1:0] mobius,
    output logic [12:0] totient,
    output logic [6:0]  divisor_count,
    output logic [15:0] divisor_sum
);

    localparam int NW = mfs_pkg::N_W;
    localparam int LW = mfs_pkg::LPF_W;
    localparam int PW = mfs_pkg::PL_AW;
    localparam int MW = mfs_pkg::MUL_W;

    mfs_pkg::state_t state_reg, state_next;

    // control and build registers
    logic [NW-1:0] limit_reg;
    logic [NW-1:0] top_reg;
    logic [NW-1:0] built_reg;
    logic          ready_reg;
    logic [PW-1:0] ptot_reg;
    logic [NW-1:0] ctr_reg;
    logic [NW-1:0] i_reg;
    logic [PW-1:0] j_reg;
    logic [LW-1:0] lpfi_reg;
    logic [NW-1:0] p_reg;
    logic [NW-1:0] x_reg;
    logic [NW-1:0] pk_reg;
    logic [NW-1:0] ppk_reg;
    logic [3:0]    a_reg;
    logic [15:0]   s_reg;
    logic [NW-1:0] idx_reg;
    mfs_pkg::entry_t ea_reg, eb_reg;
    logic [12:0]   rt_reg;
    logic [6:0]    rc_reg;

    // staged result and output register
    logic [1:0]      rstat_reg;
    mfs_pkg::entry_t rval_reg;
    logic            out_valid_reg;
    logic [1:0]      out_stat_reg;
    mfs_pkg::entry_t out_val_reg;

    // memories
    logic [LW-1:0]   lpf_mem [0:mfs_pkg::MAX_N];
    logic [LW-1:0]   quo_mem [0:mfs_pkg::MAX_N];
    logic [LW-1:0]   pl_mem  [0:mfs_pkg::MAX_PRIMES-1];
    mfs_pkg::entry_t tab_mem [0:mfs_pkg::MAX_N];

    logic [NW-1:0]   lpf_addr;
    logic            lpf_we;
    logic [LW-1:0]   lpf_wd;
    logic [LW-1:0]   quo_wd;
    logic [LW-1:0]   lpf_rd;
    logic [LW-1:0]   quo_rd;
    logic [PW-1:0]   pl_addr;
    logic            pl_we;
    logic [LW-1:0]   pl_rd;
    logic [NW-1:0]   tab_addr;
    logic            tab_we;
    mfs_pkg::entry_t tab_wd;
    mfs_pkg::entry_t tab_rd;

    logic [MW-1:0]   mul_a, mul_b;
    logic            mul_en;
    logic [2*MW-1:0] mul_prod;

    logic            in_xfer;
    logic            out_load;
    logic [NW-1:0]   top_sat;
    logic [NW-1:0]   p_sel;
    logic            div_hit;
    logic [16:0]     s_add;
    logic signed [1:0] mob_prod;
    logic [1:0]      q_stat;

    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == mfs_pkg::ST_OUT) && (!out_valid_reg || out_ready);
    assign top_sat  = (limit_reg > mfs_pkg::TOP_MAX) ? mfs_pkg::TOP_MAX : limit_reg;
    assign p_sel    = ({1'b0, lpf_rd} < NW'(2)) ? i_reg : {1'b0, lpf_rd};
    assign div_hit  = (x_reg > NW'(1)) && ({1'b0, lpf_rd} == p_reg);
    assign s_add    = {1'b0, s_reg} + {4'd0, mul_prod[NW-1:0]};

    always_comb
    begin
        if (ea_reg.mob == mfs_pkg::MOB_ZERO || eb_reg.mob == mfs_pkg::MOB_ZERO)
            mob_prod = mfs_pkg::MOB_ZERO;
        else if (ea_reg.mob == eb_reg.mob)
            mob_prod = mfs_pkg::MOB_ONE;
        else
            mob_prod = mfs_pkg::MOB_NEG;
    end

    always_comb
    begin
        if (!ready_reg)
            q_stat = mfs_pkg::STAT_NOT_BUILT;
        else if (idx_reg == '0 || idx_reg > built_reg)
            q_stat = mfs_pkg::STAT_RANGE;
        else
            q_stat = mfs_pkg::STAT_OK;
    end

    mfs_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = (func == mfs_pkg::FUNC_BUILD) ? mfs_pkg::ST_CLR
                                                               : mfs_pkg::ST_QRD;
            end
            mfs_pkg::ST_CLR:
            begin
                if (ctr_reg == mfs_pkg::TOP_MAX)
                    state_next = mfs_pkg::ST_INIT;
            end
            mfs_pkg::ST_INIT: state_next = mfs_pkg::ST_SRD;
            mfs_pkg::ST_SRD:
            begin
                state_next = (i_reg > top_reg) ? mfs_pkg::ST_FRD : mfs_pkg::ST_SLPF;
            end
            mfs_pkg::ST_SLPF: state_next = mfs_pkg::ST_SPRD;
            mfs_pkg::ST_SPRD:
            begin
                state_next = (j_reg >= ptot_reg) ? mfs_pkg::ST_SRD : mfs_pkg::ST_SMUL;
            end
            mfs_pkg::ST_SMUL: state_next = mfs_pkg::ST_SCHK;
            mfs_pkg::ST_SCHK:
            begin
                if ({1'b0, lpfi_reg} < p_reg || mul_prod > 32'(top_reg))
                    state_next = mfs_pkg::ST_SRD;
                else
                    state_next = mfs_pkg::ST_SPRD;
            end
            mfs_pkg::ST_FRD:
            begin
                state_next = (i_reg > top_reg) ? mfs_pkg::ST_OUT : mfs_pkg::ST_FP;
            end
            mfs_pkg::ST_FP:   state_next = mfs_pkg::ST_FDRD;
            mfs_pkg::ST_FDRD: state_next = mfs_pkg::ST_FDIV;
            mfs_pkg::ST_FDIV:
            begin
                if (div_hit)
                    state_next = mfs_pkg::ST_FACC;
                else if (x_reg == NW'(1))
                    state_next = mfs_pkg::ST_PPW;
                else
                    state_next = mfs_pkg::ST_TRD1;
            end
            mfs_pkg::ST_FACC: state_next = mfs_pkg::ST_FDRD;
            mfs_pkg::ST_PPW:  state_next = mfs_pkg::ST_FRD;
            mfs_pkg::ST_TRD1: state_next = mfs_pkg::ST_TRD2;
            mfs_pkg::ST_TRD2: state_next = mfs_pkg::ST_TM1;
            mfs_pkg::ST_TM1:  state_next = mfs_pkg::ST_TM2;
            mfs_pkg::ST_TM2:  state_next = mfs_pkg::ST_TM3;
            mfs_pkg::ST_TM3:  state_next = mfs_pkg::ST_TM4;
            mfs_pkg::ST_TM4:  state_next = mfs_pkg::ST_FRD;
            mfs_pkg::ST_QRD:  state_next = mfs_pkg::ST_QSET;
            mfs_pkg::ST_QSET: state_next = mfs_pkg::ST_OUT;
            mfs_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = mfs_pkg::ST_IDLE;
            end
            default: state_next = mfs_pkg::ST_IDLE;
        endcase
    end

    // memory ports and multiplier operands
    always_comb
    begin
        in_ready = (state_reg == mfs_pkg::ST_IDLE);
        lpf_addr = i_reg;
        lpf_we   = 1'b0;
        lpf_wd   = '0;
        quo_wd   = '0;
        pl_addr  = j_reg;
        pl_we    = 1'b0;
        tab_addr = i_reg;
        tab_we   = 1'b0;
        tab_wd   = '0;
        mul_a    = '0;
        mul_b    = '0;
        mul_en   = 1'b0;
        case (state_reg)
            mfs_pkg::ST_CLR:
            begin
                lpf_addr = ctr_reg;
                lpf_we   = 1'b1;
            end
            mfs_pkg::ST_INIT:
            begin
                tab_addr = NW'(1);
                tab_we   = (top_reg != '0);
                tab_wd   = '{mob: mfs_pkg::MOB_ONE, tot: 13'd1, cnt: 7'd1, sum: 16'd1};
            end
            mfs_pkg::ST_SLPF:
            begin
                // unmarked number is prime: it is its own factor, quotient one
                if (lpf_rd == '0)
                begin
                    lpf_we  = 1'b1;
                    lpf_wd  = i_reg[LW-1:0];
                    quo_wd  = LW'(1);
                    pl_addr = ptot_reg;
                    pl_we   = (ptot_reg < PW'(mfs_pkg::MAX_PRIMES));
                end
            end
            mfs_pkg::ST_SMUL:
            begin
                mul_a  = MW'(pl_rd);
                mul_b  = MW'(i_reg);
                mul_en = 1'b1;
            end
            mfs_pkg::ST_SCHK:
            begin
                lpf_addr = mul_prod[NW-1:0];
                lpf_wd   = p_reg[LW-1:0];
                quo_wd   = i_reg[LW-1:0];
                lpf_we   = !({1'b0, lpfi_reg} < p_reg || mul_prod > 32'(top_reg));
            end
            mfs_pkg::ST_FDRD:
            begin
                lpf_addr = x_reg;
            end
            mfs_pkg::ST_FDIV:
            begin
                mul_a  = MW'(pk_reg);
                mul_b  = MW'(p_reg);
                mul_en = div_hit;
            end
            mfs_pkg::ST_PPW:
            begin
                tab_we     = 1'b1;
                tab_wd.mob = (a_reg == 4'd1) ? mfs_pkg::MOB_NEG : mfs_pkg::MOB_ZERO;
                tab_wd.tot = pk_reg - ppk_reg;
                tab_wd.cnt = 7'(a_reg) + 7'd1;
                tab_wd.sum = s_reg;
            end
            mfs_pkg::ST_TRD1:
            begin
                tab_addr = pk_reg;
            end
            mfs_pkg::ST_TRD2:
            begin
                tab_addr = x_reg;
            end
            mfs_pkg::ST_TM1:
            begin
                mul_a  = MW'(ea_reg.tot);
                mul_b  = MW'(tab_rd.tot);
                mul_en = 1'b1;
            end
            mfs_pkg::ST_TM2:
            begin
                mul_a  = MW'(ea_reg.cnt);
                mul_b  = MW'(eb_reg.cnt);
                mul_en = 1'b1;
            end
            mfs_pkg::ST_TM3:
            begin
                mul_a  = ea_reg.sum;
                mul_b  = eb_reg.sum;
                mul_en = 1'b1;
            end
            mfs_pkg::ST_TM4:
            begin
                tab_we     = 1'b1;
                tab_wd.mob = mob_prod;
                tab_wd.tot = rt_reg;
                tab_wd.cnt = rc_reg;
                tab_wd.sum = (mul_prod > 32'(mfs_pkg::SUM_SAT)) ? mfs_pkg::SUM_SAT
                                                                : mul_prod[15:0];
            end
            mfs_pkg::ST_QRD:
            begin
                tab_addr = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (lpf_we)
        begin
            lpf_mem[lpf_addr] <= lpf_wd;
            quo_mem[lpf_addr] <= quo_wd;
        end
        lpf_rd <= lpf_mem[lpf_addr];
        quo_rd <= quo_mem[lpf_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
            pl_mem[pl_addr] <= i_reg[LW-1:0];
        pl_rd <= pl_mem[pl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_addr] <= tab_wd;
        tab_rd <= tab_mem[tab_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfs_pkg::ST_IDLE;
            limit_reg     <= mfs_pkg::TOP_MAX;
            ready_reg     <= 1'b0;
            built_reg     <= '0;
            ptot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (state_reg == mfs_pkg::ST_IDLE && in_xfer && func == mfs_pkg::FUNC_BUILD)
                ptot_reg <= '0;
            else if (state_reg == mfs_pkg::ST_SLPF && lpf_rd == '0 &&
                     ptot_reg < PW'(mfs_pkg::MAX_PRIMES))
                ptot_reg <= ptot_reg + PW'(1);
            if (state_reg == mfs_pkg::ST_FRD && i_reg > top_reg)
            begin
                built_reg <= top_reg;
                ready_reg <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                top_reg <= top_sat;
                ctr_reg <= '0;
                idx_reg <= index;
            end
            mfs_pkg::ST_CLR:  ctr_reg <= ctr_reg + NW'(1);
            mfs_pkg::ST_INIT: i_reg   <= NW'(2);
            mfs_pkg::ST_SRD:
            begin
                if (i_reg > top_reg)
                    i_reg <= NW'(2);
            end
            mfs_pkg::ST_SLPF:
            begin
                lpfi_reg <= (lpf_rd == '0) ? i_reg[LW-1:0] : lpf_rd;
                j_reg    <= '0;
            end
            mfs_pkg::ST_SPRD:
            begin
                if (j_reg >= ptot_reg)
                    i_reg <= i_reg + NW'(1);
            end
            mfs_pkg::ST_SMUL: p_reg <= {1'b0, pl_rd};
            mfs_pkg::ST_SCHK:
            begin
                if ({1'b0, lpfi_reg} < p_reg || mul_prod > 32'(top_reg))
                    i_reg <= i_reg + NW'(1);
                else
                    j_reg <= j_reg + PW'(1);
            end
            mfs_pkg::ST_FRD:
            begin
                rstat_reg <= mfs_pkg::STAT_OK;
                rval_reg  <= '0;
            end
            mfs_pkg::ST_FP:
            begin
                p_reg   <= p_sel;
                x_reg   <= i_reg;
                pk_reg  <= NW'(1);
                ppk_reg <= NW'(1);
                a_reg   <= '0;
                s_reg   <= 16'd1;
            end
            mfs_pkg::ST_FDIV:
            begin
                if (div_hit)
                begin
                    x_reg <= {1'b0, quo_rd};
                    a_reg <= a_reg + 4'd1;
                end
            end
            mfs_pkg::ST_FACC:
            begin
                ppk_reg <= pk_reg;
                pk_reg  <= mul_prod[NW-1:0];
                s_reg   <= s_add[16] ? mfs_pkg::SUM_SAT : s_add[15:0];
            end
            mfs_pkg::ST_PPW:  i_reg  <= i_reg + NW'(1);
            mfs_pkg::ST_TRD2: ea_reg <= tab_rd;
            mfs_pkg::ST_TM1:  eb_reg <= tab_rd;
            mfs_pkg::ST_TM2:
            begin
                rt_reg <= (mul_prod > 32'(mfs_pkg::TOT_SAT)) ? mfs_pkg::TOT_SAT
                                                             : mul_prod[12:0];
            end
            mfs_pkg::ST_TM3:
            begin
                rc_reg <= (mul_prod > 32'(mfs_pkg::CNT_SAT)) ? mfs_pkg::CNT_SAT
                                                             : mul_prod[6:0];
            end
            mfs_pkg::ST_TM4:  i_reg <= i_reg + NW'(1);
            mfs_pkg::ST_QSET:
            begin
                rstat_reg <= q_stat;
                rval_reg  <= (q_stat == mfs_pkg::STAT_OK) ? tab_rd : '0;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_stat_reg <= rstat_reg;
            out_val_reg  <= rval_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_stat_reg;
    assign mobius        = out_val_reg.mob;
    assign totient       = out_val_reg.tot;
    assign divisor_count = out_val_reg.cnt;
    assign divisor_sum   = out_val_reg.sum;

endmodule

@@ design/mfs_checker.sv @@
// Port-level checks for the multiplicative function sieve unit, with bind.
module mfs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic signed [1:0] mobius,
    input logic [12:0] totient,
    input logic [6:0]  divisor_count,
    input logic [15:0] divisor_sum
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one item at a time: intake closes after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("intake still open after transfer");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= mfs_pkg::STAT_NOT_BUILT)
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mfs_pkg::STAT_OK |->
            mobius == mfs_pkg::MOB_ZERO && totient == '0 && divisor_count == '0 &&
            divisor_sum == '0)
        else $error("values not zero on error status");

    a_mob: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mobius != 2'sb10)
        else $error("mobius out of range");

endmodule

bind multiplicative_function_sieve_unit mfs_checker u_mfs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .mobius        (mobius),
    .totient       (totient),
    .divisor_count (divisor_count),
    .divisor_sum   (divisor_sum)
);
